[rtl/lfrf_pkg.sv]
// Package for the line framing receive FIFO: operation codes, sequencer
// states, beat field widths and the newline test.
// No dependencies.
package lfrf_pkg;

  localparam int MODE_W = 3;
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 11;
  localparam int FILL_W = 11;
  localparam int LEN_W  = 10;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_ADVANCE = 3'd3,
    MODE_SKIP    = 3'd4,
    MODE_LINELEN = 3'd5,
    MODE_FLUSH   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SKIP,
    ST_SCAN,
    ST_FIN
  } state_t;

  function automatic logic is_line_end(input logic [BYTE_W-1:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

[rtl/line_framing_receive_fifo.sv]
// Line framing receive FIFO: ring byte store, pointer/count bookkeeping and
// a small sequencer that walks the store one byte per cycle.
// Depends on lfrf_pkg.
//
// Usage
//   Input beats (in_*) carry one operation each: in_tuser selects push, pop,
//   peek, advance, skip newlines, line length or flush; in_tdata carries the
//   byte to push and the peek position or advance count.
//   Each input beat yields exactly one result beat on out_*, with the byte
//   read, the fill count after the operation, the line length and flags.
//   Sequencing: push, pop, peek, advance and flush pass from acceptance
//   through the execute and finish states. Skip newlines drops the leading
//   CR/LF bytes one by one; line length drops them the same way, then scans
//   on for the line end, as the scan reads one byte of the store per cycle
//   through the single registered read port. in_tready is low while an
//   operation runs.
//   Reset clears the read pointer and fill count; the byte store keeps its
//   contents and needs no clearing pass, so the block is ready at once.
//   When the receiver stalls, the result beat holds in the output register;
//   one further operation may be accepted and run, and it waits to deliver.
module line_framing_receive_fifo #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [18:8] offset, rest zero
  input  logic [lfrf_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] mode
  input  logic [lfrf_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] read_byte, [18:8] fill_count, [28:19] line_length, [29] found,
  // [30] overflowed, [31] out_of_range
  output logic [lfrf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > lfrf_pkg::OFF_W) ? CNT_W : lfrf_pkg::OFF_W;
  localparam int SUM_W = CMP_W + 1;

  // Storage
  logic [lfrf_pkg::BYTE_W-1:0] byte_store_r [DEPTH];
  logic [lfrf_pkg::BYTE_W-1:0] rd_data_r;

  lfrf_pkg::state_t state_r, state_nxt;
  lfrf_pkg::mode_t  mode_r, mode_nxt;
  logic [lfrf_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic [lfrf_pkg::OFF_W-1:0]  off_r, off_nxt;

  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [PTR_W-1:0] sa_r, sa_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic [lfrf_pkg::BYTE_W-1:0] res_rd_r, res_rd_nxt;
  logic [CNT_W-1:0]            res_len_r, res_len_nxt;
  logic                        res_found_r, res_found_nxt;
  logic                        res_ovf_r, res_ovf_nxt;
  logic                        res_oor_r, res_oor_nxt;

  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [lfrf_pkg::BYTE_W-1:0] out_rd_r, out_rd_nxt;
  logic [lfrf_pkg::FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic [lfrf_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;
  logic                        out_found_r, out_found_nxt;
  logic                        out_ovf_r, out_ovf_nxt;
  logic                        out_oor_r, out_oor_nxt;

  logic                        wr_en;
  logic [PTR_W-1:0]            wr_addr;
  logic                        in_beat;
  logic                        full;
  logic [CMP_W-1:0]            off_w, held_w, adv_n;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Ring position base + k, valid for base + k below twice the depth
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [CMP_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(k);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign in_tready = (state_r == lfrf_pkg::ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign full      = (held_r == CNT_W'(DEPTH));
  assign off_w     = CMP_W'(off_r);
  assign held_w    = CMP_W'(held_r);
  assign adv_n     = (off_w > held_w) ? held_w : off_w;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    data_nxt      = data_r;
    off_nxt       = off_r;
    rp_nxt        = rp_r;
    held_nxt      = held_r;
    sa_nxt        = sa_r;
    idx_nxt       = idx_r;
    res_rd_nxt    = res_rd_r;
    res_len_nxt   = res_len_r;
    res_found_nxt = res_found_r;
    res_ovf_nxt   = res_ovf_r;
    res_oor_nxt   = res_oor_r;
    wr_en         = 1'b0;
    wr_addr       = slot_add(rp_r, held_w);
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_rd_nxt    = out_rd_r;
    out_fill_nxt  = out_fill_r;
    out_len_nxt   = out_len_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;
    out_oor_nxt   = out_oor_r;

    case (state_r)
      lfrf_pkg::ST_IDLE: begin
        if (in_beat) begin
          mode_nxt      = lfrf_pkg::mode_t'(in_tuser);
          data_nxt      = in_tdata[7:0];
          off_nxt       = in_tdata[18:8];
          res_rd_nxt    = '0;
          res_len_nxt   = '0;
          res_found_nxt = 1'b0;
          res_ovf_nxt   = 1'b0;
          res_oor_nxt   = 1'b0;
          // Present the first read address so the byte is there next cycle
          if (lfrf_pkg::mode_t'(in_tuser) == lfrf_pkg::MODE_PEEK) begin
            sa_nxt = slot_add(rp_r, CMP_W'(in_tdata[18:8]));
          end else begin
            sa_nxt = rp_r;
          end
          if (lfrf_pkg::mode_t'(in_tuser) == lfrf_pkg::MODE_SKIP ||
              lfrf_pkg::mode_t'(in_tuser) == lfrf_pkg::MODE_LINELEN) begin
            state_nxt = lfrf_pkg::ST_SKIP;
          end else begin
            state_nxt = lfrf_pkg::ST_EXEC;
          end
        end
      end

      lfrf_pkg::ST_EXEC: begin
        state_nxt = lfrf_pkg::ST_FIN;
        case (mode_r)
          lfrf_pkg::MODE_PUSH: begin
            wr_en = 1'b1;
            if (full) begin
              // Drop the oldest byte; the new one takes its slot
              wr_addr     = rp_r;
              rp_nxt      = ptr_inc(rp_r);
              res_ovf_nxt = 1'b1;
            end else begin
              held_nxt = held_r + CNT_W'(1);
            end
          end
          lfrf_pkg::MODE_POP: begin
            if (held_r == '0) begin
              res_oor_nxt = 1'b1;
            end else begin
              res_rd_nxt = rd_data_r;
              rp_nxt     = ptr_inc(rp_r);
              held_nxt   = held_r - CNT_W'(1);
            end
          end
          lfrf_pkg::MODE_PEEK: begin
            if (off_w >= held_w) begin
              res_oor_nxt = 1'b1;
            end else begin
              res_rd_nxt = rd_data_r;
            end
          end
          lfrf_pkg::MODE_ADVANCE: begin
            rp_nxt   = slot_add(rp_r, adv_n);
            held_nxt = held_r - CNT_W'(adv_n);
          end
          lfrf_pkg::MODE_FLUSH: begin
            rp_nxt   = '0;
            held_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      lfrf_pkg::ST_SKIP: begin
        // rd_data_r holds the head byte (sa_r tracks rp_r here)
        if (held_r == '0) begin
          state_nxt = lfrf_pkg::ST_FIN;
        end else if (lfrf_pkg::is_line_end(rd_data_r)) begin
          rp_nxt   = ptr_inc(rp_r);
          held_nxt = held_r - CNT_W'(1);
          sa_nxt   = ptr_inc(sa_r);
        end else if (mode_r == lfrf_pkg::MODE_SKIP) begin
          res_found_nxt = 1'b1;
          state_nxt     = lfrf_pkg::ST_FIN;
        end else begin
          idx_nxt   = CNT_W'(1);
          sa_nxt    = ptr_inc(sa_r);
          state_nxt = lfrf_pkg::ST_SCAN;
        end
      end

      lfrf_pkg::ST_SCAN: begin
        if (idx_r == held_r) begin
          state_nxt = lfrf_pkg::ST_FIN;
        end else if (lfrf_pkg::is_line_end(rd_data_r)) begin
          res_found_nxt = 1'b1;
          res_len_nxt   = idx_r;
          state_nxt     = lfrf_pkg::ST_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          sa_nxt  = ptr_inc(sa_r);
        end
      end

      lfrf_pkg::ST_FIN: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_rd_nxt     = res_rd_r;
          out_fill_nxt   = lfrf_pkg::FILL_W'(held_r);
          out_len_nxt    = lfrf_pkg::LEN_W'(res_len_r);
          out_found_nxt  = res_found_r;
          out_ovf_nxt    = res_ovf_r;
          out_oor_nxt    = res_oor_r;
          state_nxt      = lfrf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lfrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfrf_pkg::ST_IDLE;
      rp_r         <= '0;
      held_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      held_r       <= held_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    data_r      <= data_nxt;
    off_r       <= off_nxt;
    sa_r        <= sa_nxt;
    idx_r       <= idx_nxt;
    res_rd_r    <= res_rd_nxt;
    res_len_r   <= res_len_nxt;
    res_found_r <= res_found_nxt;
    res_ovf_r   <= res_ovf_nxt;
    res_oor_r   <= res_oor_nxt;
    out_rd_r    <= out_rd_nxt;
    out_fill_r  <= out_fill_nxt;
    out_len_r   <= out_len_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store_r[wr_addr] <= data_r;
    end
    rd_data_r <= byte_store_r[sa_nxt];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_oor_r, out_ovf_r, out_found_r, out_len_r, out_fill_r, out_rd_r};

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= PTR_W'(DEPTH - 1))
    else $error("read pointer outside the ring");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("ready stayed high after an accepted beat");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_ovf_r |-> out_fill_r == lfrf_pkg::FILL_W'(DEPTH))
    else $error("overflow reported with store not full");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_oor_r |-> out_rd_r == '0)
    else $error("out of range result carries a byte");
`endif

endmodule
